// ===== src/fack_pkg.sv =====
// ============================================================================
// fack_pkg
// Shared sizes, codes and command/status types of the acknowledgement queue.
// ============================================================================
package fack_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;

    localparam int ACTION_W    = 2;
    localparam int TYPE_W      = 8;
    localparam int ID_W        = 32;
    localparam int REF_W       = 32;
    localparam int LEN_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;
    localparam int ENTRY_W     = TYPE_W + ID_W + REF_W + REF_W + LEN_W;
    localparam int IN_DATA_W   = 128;
    localparam int OUT_DATA_W  = 128;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_REMOVE = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic    load;        // capture the input transfer, clear the scan count
        logic    push_wr;     // write the tail entry, advance tail and count
        logic    pop_commit;  // take the read entry as result, advance head
        logic    rm_commit;   // retire one entry after a removal
        logic    scan_inc;    // advance the scan position
        logic    cmp_wr;      // write read data one place toward the head
        logic    rd_plus1;    // read the entry after the scan position
        logic    set_status;  // load the result status
        status_t status;
        logic    present;     // move the result into the output register
    } fack_cmd_t;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                full;
        logic                empty;
        logic                match;
        logic                last1;   // scan position is the newest entry
        logic                last2;   // scan position is the second newest entry
        logic                out_free;
    } fack_stat_t;

    function automatic logic [IDX_W-1:0] idx_wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        begin
            r = s;
            if (s >= SUM_W'(QUEUE_DEPTH))
            begin
                r = s - SUM_W'(QUEUE_DEPTH);
            end
            return r[IDX_W-1:0];
        end
    endfunction

endpackage

// ===== src/fack_ctrl.sv =====
// ============================================================================
// fack_ctrl
// Sequencer for push, pop and acknowledgement removal with compaction.
// ============================================================================
module fack_ctrl
    import fack_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  fack_stat_t stat,
    output fack_cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DECODE   = 7'b0000010,
        S_POP_DATA = 7'b0000100,
        S_SCAN_CHK = 7'b0001000,
        S_CMP_WR   = 7'b0010000,
        S_CMP_RD   = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                // The head entry is read here; pop and scan use it next cycle.
                cmd.set_status = 1'b1;
                state_next     = S_DONE;
                case (stat.action)
                    ACT_PUSH:
                    begin
                        if (stat.full)
                        begin
                            cmd.status = ST_FULL;
                        end
                        else
                        begin
                            cmd.push_wr = 1'b1;
                            cmd.status  = ST_OK;
                        end
                    end
                    ACT_POP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.status = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.set_status = 1'b0;
                            state_next     = S_POP_DATA;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        cmd.status = ST_NOT_FOUND;
                        if (!stat.empty)
                        begin
                            cmd.set_status = 1'b0;
                            state_next     = S_SCAN_CHK;
                        end
                    end
                    default:
                    begin
                        cmd.status = ST_NOT_FOUND;
                    end
                endcase
            end
            S_POP_DATA:
            begin
                cmd.pop_commit = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = ST_OK;
                state_next     = S_DONE;
            end
            S_SCAN_CHK:
            begin
                // Fetch the following entry: the next probe or the first move.
                cmd.rd_plus1 = 1'b1;
                if (stat.match)
                begin
                    if (stat.last1)
                    begin
                        cmd.rm_commit  = 1'b1;
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_OK;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        state_next = S_CMP_WR;
                    end
                end
                else if (stat.last1)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NOT_FOUND;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                end
            end
            S_CMP_WR:
            begin
                cmd.cmp_wr   = 1'b1;
                cmd.scan_inc = 1'b1;
                if (stat.last2)
                begin
                    cmd.rm_commit  = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_OK;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_CMP_RD;
                end
            end
            S_CMP_RD:
            begin
                cmd.rd_plus1 = 1'b1;
                state_next   = S_CMP_WR;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.present = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/fack_dp.sv =====
// ============================================================================
// fack_dp
// Entry memory, ring pointers, scan counter and result/output registers.
// ============================================================================
module fack_dp
    import fack_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  fack_cmd_t             cmd,
    output fack_stat_t            stat,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic                  cfg_we,
    input  logic [TYPE_W-1:0]     cfg_wdata,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    // Entry layout: type, id, topic, payload ref, payload length (low to high).
    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [TYPE_W-1:0]   ack_code_reg;
    logic [ACTION_W-1:0] action_reg;
    logic [ENTRY_W-1:0]  in_entry_reg;
    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    tail_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    scan_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [ENTRY_W-1:0]  res_entry_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [SUM_W-1:0]  scan_sum;
    logic [IDX_W-1:0]  scan_addr;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic              wr_en;
    logic [IDX_W-1:0]  tail_dec;

    assign scan_sum  = SUM_W'(head_reg) + SUM_W'(scan_reg);
    assign scan_addr = idx_wrap(scan_sum);
    assign rd_addr   = idx_wrap(scan_sum + SUM_W'(cmd.rd_plus1));
    assign wr_en     = cmd.push_wr | cmd.cmp_wr;
    assign wr_addr   = cmd.push_wr ? tail_reg : scan_addr;
    assign wr_data   = cmd.push_wr ? in_entry_reg : rd_data_reg;
    assign tail_dec  = (tail_reg == '0) ? IDX_W'(QUEUE_DEPTH - 1) : tail_reg - 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_code_reg  <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            action_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ack_code_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                action_reg <= in_data[ACTION_W-1:0];
                scan_reg   <= '0;
            end
            else if (cmd.scan_inc)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.push_wr)
            begin
                tail_reg  <= idx_wrap(SUM_W'(tail_reg) + SUM_W'(1));
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.pop_commit)
            begin
                head_reg  <= idx_wrap(SUM_W'(head_reg) + SUM_W'(1));
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.rm_commit)
            begin
                tail_reg  <= tail_dec;
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.present)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_entry_reg  <= in_data[ACTION_W +: ENTRY_W];
            res_entry_reg <= '0;
        end
        else if (cmd.pop_commit)
        begin
            res_entry_reg <= rd_data_reg;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status;
        end
        if (cmd.present)
        begin
            out_data_reg <= {1'b0, COUNT_W'(count_reg), res_entry_reg, res_status_reg};
        end
    end

    assign stat.action   = action_reg;
    assign stat.full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty    = (count_reg == '0);
    assign stat.match    = (rd_data_reg[TYPE_W-1:0] == ack_code_reg)
                        && (rd_data_reg[TYPE_W +: ID_W] == in_entry_reg[TYPE_W +: ID_W]);
    assign stat.last1    = (SUM_W'(scan_reg) + SUM_W'(1)) >= SUM_W'(count_reg);
    assign stat.last2    = (SUM_W'(scan_reg) + SUM_W'(2)) >= SUM_W'(count_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== src/fifo_with_ack_match_removal_unit.sv =====
// ============================================================================
// fifo_with_ack_match_removal_unit
// Bounded message-descriptor queue with push, pop and ack-match removal.
// ============================================================================
//
// Channel   Direction  Handshake                 Carries
// s_axis    in         s_axis_tvalid/tready      one action with its fields
// m_axis    out        m_axis_tvalid/tready      one result per action
// cfg       in         cfg_we (no wait)          ack_type_code
//
// Steps per transfer: a push or failed action goes through decode and done, a
// pop adds a data step, and a remove-ack probes each scan position up to the hit
// or miss, then moves every later entry up one place (worst case a hit at the
// head of a full queue). The entry memory with its registered read makes each
// move of the compaction loop take one write state and one read state.
// Reset clears pointers, occupancy and the ack code; entry contents are left
// undefined and never read before written.
// A finished result waits in the output register; a new action is accepted
// while it waits, and only the hand-off of the next result stalls on m_axis.
//
module fifo_with_ack_match_removal_unit
    import fack_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // action[1:0], msg_kind[9:2], msg_id[41:10], topic_ref[73:42],
    // payload_ref[105:74], payload_len[121:106], zero [127:122]
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // status[1:0], out_msg_kind[9:2], out_msg_id[41:10], out_topic_ref[73:42],
    // out_payload_ref[105:74], out_payload_len[121:106], entry_count[126:122],
    // zero [127]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [TYPE_W-1:0]     cfg_wdata
);

    fack_cmd_t  cmd;
    fack_stat_t stat;

    // Sequence each action: decode, probe, compact, present.
    fack_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold entries, pointers and the result/output registers.
    fack_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== src/fack_chk.sv =====
// ============================================================================
// fack_chk
// Port-level checks on the acknowledgement queue results.
// ============================================================================
module fack_chk
    import fack_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int CNT_LSB = STATUS_W + ENTRY_W;

    logic [STATUS_W-1:0] r_status;
    logic [COUNT_W-1:0]  r_count;
    logic [ENTRY_W-1:0]  r_entry;

    assign r_status = m_axis_tdata[STATUS_W-1:0];
    assign r_entry  = m_axis_tdata[STATUS_W +: ENTRY_W];
    assign r_count  = m_axis_tdata[CNT_LSB +: COUNT_W];

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> r_count <= COUNT_W'(QUEUE_DEPTH))
        else $error("entry count above depth");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && r_status == ST_FULL |-> r_count == COUNT_W'(QUEUE_DEPTH))
        else $error("full reported below depth");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && r_status == ST_EMPTY |-> r_count == '0 && r_entry == '0)
        else $error("empty result with entries or data");

endmodule

bind fifo_with_ack_match_removal_unit fack_chk u_fack_chk (.*);

// ===== tb/fifo_with_ack_match_removal_unit_test.sv =====
// ============================================================================
// fifo_with_ack_match_removal_unit_test
// Self-checking bench for the message-descriptor queue. A scoreboard class
// shadows the queue contents and the ack code. It predicts status, the popped
// descriptor and the entry count of every transfer on the input stream, and
// checks each result transfer field by field. The stimulus starts with a short
// directed pass over the corner cases. It then runs random phases with
// fill/drain bursts and random idling on both streams. The ack code is
// rewritten between phases.
// ============================================================================
module fifo_with_ack_match_removal_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fack_pkg::*;

    // Action code 3 has no package name; the block answers it with not found.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // Worst-case block latency: a remove that hits the head of a full queue and
    // compacts every later entry, with some margin.
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS   = 190;
    localparam int ID_POOL_SIZE  = 8;

    typedef struct packed {
        logic [TYPE_W-1:0] msg_kind;
        logic [ID_W-1:0]   msg_id;
        logic [REF_W-1:0]  topic_ref;
        logic [REF_W-1:0]  payload_ref;
        logic [LEN_W-1:0]  payload_len;
    } descriptor_t;

    typedef struct {
        logic [ACTION_W-1:0] action;
        descriptor_t         desc;
    } request_t;

    typedef struct {
        status_t            status;
        descriptor_t        desc;
        logic [COUNT_W-1:0] count;
    } outcome_t;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } burst_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow queue in arrival order plus the outcomes still owed.
    // ------------------------------------------------------------------------
    class ack_queue_scoreboard;
        descriptor_t       held[$];
        outcome_t          owed[$];
        logic [TYPE_W-1:0] ack_code;
        int unsigned       failures;

        function new();
            ack_code = '0;
            failures = 0;
        endfunction

        function void set_ack_code(logic [TYPE_W-1:0] code);
            ack_code = code;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Apply one accepted request to the shadow queue and queue its outcome.
        function void note_request(request_t req);
            outcome_t res;
            res.status = ST_OK;
            res.desc   = '0;
            case (req.action)
                ACT_PUSH:
                begin
                    if (held.size() >= QUEUE_DEPTH)
                        res.status = ST_FULL;
                    else
                        held.push_back(req.desc);
                end
                ACT_POP:
                begin
                    if (held.size() == 0)
                        res.status = ST_EMPTY;
                    else
                        res.desc = held.pop_front();
                end
                ACT_REMOVE:
                begin
                    // Oldest matching ack goes; later entries close the gap.
                    res.status = ST_NOT_FOUND;
                    for (int i = 0; i < held.size(); i++)
                    begin
                        if (held[i].msg_kind == ack_code && held[i].msg_id == req.desc.msg_id)
                        begin
                            held.delete(i);
                            res.status = ST_OK;
                            break;
                        end
                    end
                end
                default:
                begin
                    res.status = ST_NOT_FOUND;
                end
            endcase
            res.count = COUNT_W'(held.size());
            owed.push_back(res);
        endfunction

        function void compare_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
            if (want !== got)
            begin
                $display("%0d ns: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            outcome_t    want;
            descriptor_t got;
            got.msg_kind    = data[9:2];
            got.msg_id      = data[41:10];
            got.topic_ref   = data[73:42];
            got.payload_ref = data[105:74];
            got.payload_len = data[121:106];
            if (owed.size() == 0)
            begin
                $display("%0d ns: result with nothing expected, expected none, got 0x%0h",
                         $time, data);
                failures++;
                return;
            end
            want = owed.pop_front();
            compare_field("status", ID_W'(want.status), ID_W'(data[1:0]));
            compare_field("out_msg_kind", ID_W'(want.desc.msg_kind), ID_W'(got.msg_kind));
            compare_field("out_msg_id", want.desc.msg_id, got.msg_id);
            compare_field("out_topic_ref", want.desc.topic_ref, got.topic_ref);
            compare_field("out_payload_ref", want.desc.payload_ref, got.payload_ref);
            compare_field("out_payload_len", ID_W'(want.desc.payload_len),
                          ID_W'(got.payload_len));
            compare_field("entry_count", ID_W'(want.count), ID_W'(data[126:122]));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // action[1:0], msg_kind[9:2], msg_id[41:10], topic_ref[73:42],
    // payload_ref[105:74], payload_len[121:106], zero [127:122]
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // status[1:0], out_msg_kind[9:2], out_msg_id[41:10], out_topic_ref[73:42],
    // out_payload_ref[105:74], out_payload_len[121:106], entry_count[126:122],
    // zero [127]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we;
    logic [TYPE_W-1:0]     cfg_wdata;

    fifo_with_ack_match_removal_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    ack_queue_scoreboard board;

    // Set while a burst runs with no idling on either stream.
    bit                steady;
    // Ack code as last written; random pushes aim at it so removals can hit.
    logic [TYPE_W-1:0] ack_code_now;
    // Small id set so that removals find their acks often.
    logic [ID_W-1:0]   id_pool[ID_POOL_SIZE];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #4_000_000;
        $display("fifo_with_ack_match_removal_unit_test: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Idle length: mostly none or short, now and then a long gap.
    // ------------------------------------------------------------------------
    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: hold tready low for random stalls, change it at the falling
    // edge only.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                stall = idle_cycles();
                m_axis_tready <= (stall == 0);
            end
        end
    end

    // Check every result transfer at the rising edge, before the block updates.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    function automatic request_t make_request(logic [ACTION_W-1:0] action,
                                              logic [TYPE_W-1:0] msg_kind,
                                              logic [ID_W-1:0] msg_id,
                                              logic [REF_W-1:0] topic_ref,
                                              logic [REF_W-1:0] payload_ref,
                                              logic [LEN_W-1:0] payload_len);
        request_t req;
        req.action           = action;
        req.desc.msg_kind    = msg_kind;
        req.desc.msg_id      = msg_id;
        req.desc.topic_ref   = topic_ref;
        req.desc.payload_ref = payload_ref;
        req.desc.payload_len = payload_len;
        return req;
    endfunction

    // Drive one request at the falling edge, hold it until the transfer, then
    // note it. tvalid stays high into the next request unless a gap follows.
    task automatic send_request(input request_t req);
        int gap;
        gap = idle_cycles();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, req.desc.payload_len, req.desc.payload_ref,
                          req.desc.topic_ref, req.desc.msg_id, req.desc.msg_kind,
                          req.action};
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        board.note_request(req);
    endtask

    task automatic release_input();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Drain every owed result, let the block settle, then rewrite the ack code.
    task automatic write_ack_code(input logic [TYPE_W-1:0] code);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wdata <= code;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        board.set_ack_code(code);
        ack_code_now = code;
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 99) < 85)
            return id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // Random request; the burst mode sets the mix of actions so the queue
    // swings between full and empty.
    function automatic request_t random_request(burst_mode_t mode);
        request_t req;
        int       roll;
        int       push_pct;
        int       pop_pct;
        int       remove_pct;
        int       len_roll;
        case (mode)
            MODE_FILL:
            begin
                push_pct = 75; pop_pct = 10; remove_pct = 12;
            end
            MODE_DRAIN:
            begin
                push_pct = 10; pop_pct = 35; remove_pct = 50;
            end
            default:
            begin
                push_pct = 40; pop_pct = 25; remove_pct = 30;
            end
        endcase
        req = make_request(ACT_UNUSED, TYPE_W'($urandom), $urandom, $urandom, $urandom,
                           LEN_W'($urandom));
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
        begin
            req.action = ACT_PUSH;
            if ($urandom_range(0, 99) < 60)
                req.desc.msg_kind = ack_code_now;
            req.desc.msg_id = pick_id();
            len_roll = $urandom_range(0, 9);
            if (len_roll == 0)
                req.desc.payload_len = '0;
            else if (len_roll == 1)
                req.desc.payload_len = '1;
        end
        else if (roll < push_pct + pop_pct)
        begin
            req.action = ACT_POP;
        end
        else if (roll < push_pct + pop_pct + remove_pct)
        begin
            req.action      = ACT_REMOVE;
            req.desc.msg_id = pick_id();
        end
        return req;
    endfunction

    task automatic run_random_phase(input int items);
        burst_mode_t mode;
        int          left;
        mode = MODE_MIX;
        left = 0;
        for (int n = 0; n < items; n++)
        begin
            // Switch burst mode and idling now and then.
            if (left == 0)
            begin
                mode   = burst_mode_t'($urandom_range(0, 2));
                left   = $urandom_range(8, 30);
                steady = ($urandom_range(0, 3) == 0);
            end
            send_request(random_request(mode));
            left--;
        end
        steady = 1'b0;
        release_input();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [TYPE_W-1:0] phase_codes[6];

        board         = new();
        steady        = 1'b0;
        ack_code_now  = '0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed pass, ack code still at its reset value of zero.
        // Empty queue: pop reports empty, remove misses, action 3 is refused.
        send_request(make_request(ACT_POP, '0, '0, '0, '0, '0));
        send_request(make_request(ACT_REMOVE, '0, '0, '0, '0, '0));
        send_request(make_request(ACT_UNUSED, '1, '1, '1, '1, '1));
        // Field extremes through push and pop.
        send_request(make_request(ACT_PUSH, '0, '0, '0, '0, '0));
        send_request(make_request(ACT_PUSH, '1, '1, '1, '1, '1));
        send_request(make_request(ACT_POP, '0, '0, '0, '0, '0));
        send_request(make_request(ACT_POP, '1, '1, '1, '1, '1));
        send_request(make_request(ACT_POP, '0, '0, '0, '0, '0));
        // Id 5 as a plain message, then two acks with id 5 around an ack with id 6.
        send_request(make_request(ACT_PUSH, 8'h07, 32'd5, 32'h1111_0001, 32'h2222_0001, 16'd1));
        send_request(make_request(ACT_PUSH, 8'h00, 32'd5, 32'h1111_0002, 32'h2222_0002, 16'd2));
        send_request(make_request(ACT_PUSH, 8'h00, 32'd6, 32'h1111_0003, 32'h2222_0003, 16'd3));
        send_request(make_request(ACT_PUSH, 8'h00, 32'd5, 32'h1111_0004, 32'h2222_0004, 16'd4));
        // First remove hits the older ack and compacts; the second hits the
        // newest entry; the third finds only the plain message and misses.
        send_request(make_request(ACT_REMOVE, '0, 32'd5, '0, '0, '0));
        send_request(make_request(ACT_REMOVE, '0, 32'd5, '0, '0, '0));
        send_request(make_request(ACT_REMOVE, '0, 32'd5, '0, '0, '0));
        send_request(make_request(ACT_REMOVE, '0, 32'd6, '0, '0, '0));
        send_request(make_request(ACT_UNUSED, 8'h5A, $urandom, $urandom, $urandom, 16'hA5A5));
        send_request(make_request(ACT_POP, '0, '0, '0, '0, '0));
        send_request(make_request(ACT_POP, '0, '0, '0, '0, '0));
        // Remove the head entry, leave the younger same-id non-ack behind.
        send_request(make_request(ACT_PUSH, 8'h00, 32'd9, 32'h3333_0001, 32'h4444_0001, 16'd9));
        send_request(make_request(ACT_PUSH, 8'h01, 32'd9, 32'h3333_0002, 32'h4444_0002, 16'd8));
        send_request(make_request(ACT_REMOVE, '0, 32'd9, '0, '0, '0));
        send_request(make_request(ACT_POP, '0, '0, '0, '0, '0));
        send_request(make_request(ACT_POP, '0, '0, '0, '0, '0));
        release_input();

        // Random phases, each under its own ack code, extremes first.
        phase_codes[0] = 8'hFF;
        phase_codes[1] = 8'h00;
        phase_codes[2] = 8'hA5;
        phase_codes[3] = 8'h5A;
        phase_codes[4] = TYPE_W'($urandom);
        phase_codes[5] = TYPE_W'($urandom);
        foreach (phase_codes[p])
        begin
            write_ack_code(phase_codes[p]);
            id_pool[0] = '0;
            id_pool[1] = '1;
            for (int k = 2; k < ID_POOL_SIZE; k++)
                id_pool[k] = $urandom;
            run_random_phase(PHASE_ITEMS);
        end

        // Drain, then allow time for any stray result to show up.
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.failures == 0)
            $display("fifo_with_ack_match_removal_unit_test: PASS");
        else
            $display("fifo_with_ack_match_removal_unit_test: FAIL");
        $finish;
    end

endmodule
